// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL of the door controller.
// Every check is sampled on the rising edge of clk and is held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication that must hold from the antecedent cycle onwards.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/doc_pkg.sv =====
`default_nettype none

package doc_pkg;

  // Number of travel steps between fully closed and fully open.
  localparam logic [2:0] TRAVEL_STEPS = 3'd5;

  // Reset values of the configuration registers and of the countdown.
  localparam logic [7:0] AUTO_CLOSE_RESET = 8'd10;
  localparam logic [1:0] SENSORS_RESET    = 2'd1;

  // Indexes of the configuration registers.
  localparam logic CFG_AUTO_CLOSE = 1'b0;
  localparam logic CFG_SENSORS    = 1'b1;

  // Event kinds carried on the input side.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_OPEN   = 3'd1;
  localparam logic [2:0] KIND_STOP   = 3'd2;
  localparam logic [2:0] KIND_CLOSE  = 3'd3;
  localparam logic [2:0] KIND_SENSOR = 3'd4;

  // Door state codes as reported on the output side.
  localparam logic [2:0] CODE_CLOSED  = 3'd0;
  localparam logic [2:0] CODE_CLOSING = 3'd1;
  localparam logic [2:0] CODE_OPENED  = 3'd2;
  localparam logic [2:0] CODE_OPENING = 3'd3;
  localparam logic [2:0] CODE_BLOCKED = 3'd4;
  localparam logic [2:0] CODE_STOPPED = 3'd5;

  typedef enum logic [5:0] {
    MODE_CLOSED  = 6'b000001,
    MODE_CLOSING = 6'b000010,
    MODE_OPENED  = 6'b000100,
    MODE_OPENING = 6'b001000,
    MODE_BLOCKED = 6'b010000,
    MODE_STOPPED = 6'b100000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] position;
    logic [7:0] countdown;
  } door_t;

  function automatic logic [2:0] mode_code(input mode_t mode);
    logic [2:0] code;
    unique case (mode)
      MODE_CLOSED:  code = CODE_CLOSED;
      MODE_CLOSING: code = CODE_CLOSING;
      MODE_OPENED:  code = CODE_OPENED;
      MODE_OPENING: code = CODE_OPENING;
      MODE_BLOCKED: code = CODE_BLOCKED;
      MODE_STOPPED: code = CODE_STOPPED;
      default:      code = CODE_CLOSED;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/door_opener_controller_unit.sv =====
// Garage door controller.
// Input stream: one event per request. s_tuser carries the event kind (tick, open,
// stop, close, sensor update); s_tdata carries the sensor levels, read on sensor
// updates only. Output stream: one result per input request, giving the door
// state, the travel position, a moving flag and the auto-close countdown as they
// stand after the event.
// A result is presented on m_tvalid in the cycle after its request is taken.
// Throughput: one request per cycle; the state update is a single pass of logic
// from the current state and the incoming event into the state and result registers.
// When the receiver stalls, the one result register holds its content and
// s_tready drops until that result has been taken; nothing is lost or repeated.
// Configuration: cfg_addr 0 sets the auto-close tick count and cfg_addr 1 the
// number of sensors in use. Writes take effect at once and belong in idle periods.
// Reset (synchronous, rst high): the door is closed at position zero, the countdown
// holds ten, the registers return to ten ticks and one sensor, and no result is
// pending.
`default_nettype none
`include "assert_macros.svh"

module door_opener_controller_unit
  import doc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [2:0] sensor_levels, [7:3] zero
  input  wire logic [2:0]  s_tuser,  // [2:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // [2:0] door_state, [5:3] travel_position,
                                     // [6] moving, [14:7] close_countdown, [15] zero
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0] auto_close_ticks;
  logic [1:0] sensors_in_use;
  door_t      door;
  door_t      door_next;
  logic       s_accept;
  logic       m_accept;
  logic       moving_next;
  logic [7:0] countdown_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_close_ticks <= AUTO_CLOSE_RESET;
      sensors_in_use   <= SENSORS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_AUTO_CLOSE: auto_close_ticks <= cfg_data;
        CFG_SENSORS:    sensors_in_use   <= cfg_data[1:0];
        default:        auto_close_ticks <= auto_close_ticks;
      endcase
    end
  end

  doc_step u_step (
    .kind             (s_tuser),
    .sensor_levels    (s_tdata[2:0]),
    .auto_close_ticks (auto_close_ticks),
    .sensors_in_use   (sensors_in_use),
    .cur              (door),
    .nxt              (door_next)
  );

  assign m_accept = m_tvalid && m_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  assign moving_next    = (door_next.mode == MODE_OPENING) || (door_next.mode == MODE_CLOSING);
  assign countdown_next = (door_next.mode == MODE_OPENED) ? door_next.countdown : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      door.mode      <= MODE_CLOSED;
      door.position  <= 3'd0;
      door.countdown <= AUTO_CLOSE_RESET;
    end else if (s_accept) begin
      door <= door_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_accept) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {1'b0, countdown_next, moving_next, door_next.position,
                  mode_code(door_next.mode)};
    end
  end

  `ASSERT_CLK(a_pos_range, door.position <= TRAVEL_STEPS, "position beyond full travel")
  `ASSERT_IMPL(a_no_take_on_stall, m_tvalid && !m_tready, !s_tready,
    "request taken while a result is stalled")
  `ASSERT_IMPL(a_moving_flag, m_tvalid,
    m_tdata[6] == (m_tdata[2:0] == CODE_OPENING || m_tdata[2:0] == CODE_CLOSING),
    "moving flag disagrees with reported state")
  `ASSERT_IMPL(a_countdown_zero, m_tvalid && m_tdata[2:0] != CODE_OPENED,
    m_tdata[14:7] == 8'd0, "countdown reported outside the opened state")
  `ASSERT_NEXT(a_state_held, !s_accept, $stable(door), "door state changed without a request")

endmodule

`default_nettype wire

// ===== rtl/core/doc_step.sv =====
`default_nettype none

module doc_step
  import doc_pkg::*;
(
  input  wire logic [2:0] kind,
  input  wire logic [2:0] sensor_levels,
  input  wire logic [7:0] auto_close_ticks,
  input  wire logic [1:0] sensors_in_use,
  input  wire door_t      cur,
  output door_t           nxt
);

  door_t      tick_st;
  logic       is_moving;
  logic [2:0] sensor_mask;
  logic       obstacle;

  // Tick: step the position, complete the motion at an end, then run the
  // auto-close countdown (also on the tick that has just finished opening).
  always_comb begin
    tick_st   = cur;
    is_moving = (cur.mode == MODE_OPENING) || (cur.mode == MODE_CLOSING);
    if (cur.mode == MODE_OPENING && cur.position < TRAVEL_STEPS) begin
      tick_st.position = cur.position + 3'd1;
    end
    if (cur.mode == MODE_CLOSING && cur.position != 3'd0) begin
      tick_st.position = cur.position - 3'd1;
    end
    if (is_moving && (tick_st.position == 3'd0 || tick_st.position == TRAVEL_STEPS)) begin
      if (cur.mode == MODE_OPENING) begin
        tick_st.mode      = MODE_OPENED;
        tick_st.countdown = auto_close_ticks;
      end else begin
        tick_st.mode = MODE_CLOSED;
      end
    end
    if (tick_st.mode == MODE_OPENED) begin
      if (tick_st.countdown == 8'd0) begin
        tick_st.mode = MODE_CLOSING;
      end else begin
        tick_st.countdown = tick_st.countdown - 8'd1;
      end
    end
  end

  // A setting of zero sensors behaves as one sensor.
  always_comb begin
    case (sensors_in_use)
      2'd2:    sensor_mask = 3'b011;
      2'd3:    sensor_mask = 3'b111;
      default: sensor_mask = 3'b001;
    endcase
    obstacle = (sensor_levels & sensor_mask) != sensor_mask;
  end

  always_comb begin
    nxt = cur;
    unique case (kind)
      KIND_TICK: begin
        nxt = tick_st;
      end
      KIND_OPEN: begin
        if (cur.mode == MODE_CLOSED || cur.mode == MODE_STOPPED) begin
          nxt.mode = MODE_OPENING;
        end
      end
      KIND_STOP: begin
        if (cur.mode == MODE_OPENING || cur.mode == MODE_CLOSING) begin
          nxt.mode = MODE_STOPPED;
        end
      end
      KIND_CLOSE: begin
        if (cur.mode == MODE_OPENED || cur.mode == MODE_STOPPED) begin
          nxt.mode = MODE_CLOSING;
        end
      end
      KIND_SENSOR: begin
        if (obstacle) begin
          nxt.mode = MODE_BLOCKED;
        end else if (cur.mode == MODE_BLOCKED) begin
          if (cur.position == 3'd0) begin
            nxt.mode = MODE_CLOSED;
          end else if (cur.position == TRAVEL_STEPS) begin
            nxt.mode      = MODE_OPENED;
            nxt.countdown = auto_close_ticks;
          end else begin
            nxt.mode = MODE_STOPPED;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/door_opener_controller_unit_tb.sv =====
`default_nettype none

module door_opener_controller_unit_tb
  import doc_pkg::*;
();

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 60;

  // One result word as it leaves the block, lowest field in the lowest bits.
  typedef struct packed {
    logic       pad;
    logic [7:0] countdown;
    logic       moving;
    logic [2:0] position;
    logic [2:0] state;
  } door_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [2:0]  s_tuser = 3'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_data = 8'd0;

  // Predicted door and register state.
  logic [2:0] door_mode      = CODE_CLOSED;
  logic [2:0] door_pos       = 3'd0;
  logic [7:0] door_countdown = AUTO_CLOSE_RESET;
  logic [7:0] close_delay    = AUTO_CLOSE_RESET;
  logic [1:0] sensor_count   = SENSORS_RESET;

  door_report_t pending_reports[$];
  int fault_count = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  door_opener_controller_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),  // [2:0] sensor_levels, [7:3] zero
    .s_tuser  (s_tuser),  // [2:0] kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),  // [2:0] door_state, [5:3] travel_position, [6] moving,
                          // [14:7] close_countdown, [15] zero
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic advance_door(input logic [2:0] kind, input logic [2:0] levels,
                              output door_report_t rep);
    logic       was_moving;
    logic [1:0] used;
    logic [2:0] mask;
    case (kind)
      KIND_TICK: begin
        was_moving = (door_mode == CODE_OPENING) || (door_mode == CODE_CLOSING);
        if (door_mode == CODE_OPENING && door_pos < TRAVEL_STEPS) door_pos = door_pos + 3'd1;
        if (door_mode == CODE_CLOSING && door_pos != 3'd0) door_pos = door_pos - 3'd1;
        if (was_moving && (door_pos == 3'd0 || door_pos == TRAVEL_STEPS)) begin
          if (door_mode == CODE_OPENING) begin
            door_mode = CODE_OPENED;
            door_countdown = close_delay;
          end else begin
            door_mode = CODE_CLOSED;
          end
        end
        // The countdown check also runs on the tick that finished opening.
        if (door_mode == CODE_OPENED) begin
          if (door_countdown == 8'd0) door_mode = CODE_CLOSING;
          else door_countdown = door_countdown - 8'd1;
        end
      end
      KIND_OPEN: begin
        if (door_mode == CODE_CLOSED || door_mode == CODE_STOPPED) door_mode = CODE_OPENING;
      end
      KIND_STOP: begin
        if (door_mode == CODE_OPENING || door_mode == CODE_CLOSING) door_mode = CODE_STOPPED;
      end
      KIND_CLOSE: begin
        if (door_mode == CODE_OPENED || door_mode == CODE_STOPPED) door_mode = CODE_CLOSING;
      end
      KIND_SENSOR: begin
        used = (sensor_count == 2'd0) ? 2'd1 : sensor_count;
        mask = (3'b001 << used) - 3'b001;
        if ((levels & mask) != mask) begin
          door_mode = CODE_BLOCKED;
        end else if (door_mode == CODE_BLOCKED) begin
          if (door_pos == 3'd0) begin
            door_mode = CODE_CLOSED;
          end else if (door_pos == TRAVEL_STEPS) begin
            door_mode = CODE_OPENED;
            door_countdown = close_delay;
          end else begin
            door_mode = CODE_STOPPED;
          end
        end
      end
      default: ;
    endcase
    rep.pad       = 1'b0;
    rep.state     = door_mode;
    rep.position  = door_pos;
    rep.moving    = (door_mode == CODE_OPENING) || (door_mode == CODE_CLOSING);
    rep.countdown = (door_mode == CODE_OPENED) ? door_countdown : 8'd0;
  endtask

  task automatic send_event(input logic [2:0] kind, input logic [2:0] levels);
    door_report_t rep;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, levels};
    do @(posedge clk); while (!s_tready);
    advance_door(kind, levels, rep);
    pending_reports.push_back(rep);
  endtask

  // Stops offering requests and waits until every result has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AUTO_CLOSE) close_delay = value;
    else sensor_count = value[1:0];
  endtask

  task automatic send_random_event();
    int r;
    logic [2:0] kind;
    logic [2:0] levels;
    r = $urandom_range(99);
    if (r < 45) kind = KIND_TICK;
    else if (r < 57) kind = KIND_OPEN;
    else if (r < 65) kind = KIND_STOP;
    else if (r < 77) kind = KIND_CLOSE;
    else if (r < 95) kind = KIND_SENSOR;
    else kind = 3'($urandom_range(7, 5));
    // Mostly clear sensors, so that the door gets to travel between obstacles.
    if (kind == KIND_SENSOR && $urandom_range(99) < 65) levels = 3'b111;
    else levels = 3'($urandom_range(7));
    send_event(kind, levels);
  endtask

  task automatic test_directed();
    write_reg(CFG_AUTO_CLOSE, AUTO_CLOSE_RESET);
    write_reg(CFG_SENSORS, 8'(SENSORS_RESET));
    // Obstacle while closed, then cleared at position zero.
    send_event(KIND_SENSOR, 3'b110);
    send_event(KIND_SENSOR, 3'b001);
    send_event(KIND_OPEN, 3'b000);
    repeat (5) send_event(KIND_TICK, 3'b111);
    send_event(3'd5, 3'b111);
    // Blocked at full travel: no movement, commands ignored, clears to opened.
    send_event(KIND_SENSOR, 3'b000);
    send_event(KIND_TICK, 3'b000);
    send_event(KIND_OPEN, 3'b000);
    send_event(KIND_SENSOR, 3'b111);
    send_event(KIND_CLOSE, 3'b000);
    send_event(KIND_TICK, 3'b000);
    send_event(KIND_STOP, 3'b000);
    send_event(KIND_CLOSE, 3'b000);
    send_event(KIND_STOP, 3'b000);
    // Blocked midway clears to stopped.
    send_event(KIND_SENSOR, 3'b010);
    send_event(KIND_SENSOR, 3'b101);
    send_event(KIND_OPEN, 3'b000);
    send_event(3'd7, 3'b000);
    send_event(3'd6, 3'b010);
  endtask

  task automatic test_random_phase(input logic [7:0] delay, input logic [1:0] sensors,
                                   input int count);
    write_reg(CFG_AUTO_CLOSE, delay);
    write_reg(CFG_SENSORS, {6'd0, sensors});
    repeat (count) send_random_event();
  endtask

  // The receiver holds off while requests keep coming, so the block must stall its input.
  task automatic test_receiver_hold();
    src_idle = 0;
    snk_idle = 0;
    write_reg(CFG_AUTO_CLOSE, 8'($urandom_range(8, 1)));
    write_reg(CFG_SENSORS, 8'($urandom_range(3, 1)));
    hold_req = 1;
    repeat (30) send_random_event();
  endtask

  task automatic test_sender_pause();
    src_idle = 20;
    snk_idle = 20;
    repeat (15) send_random_event();
    settle();
    repeat (15) send_random_event();
  endtask

  task automatic report_fault(input string what, input int unsigned exp_val,
                              input int unsigned act_val);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    door_report_t exp_rep;
    door_report_t act_rep;
    if (!rst && m_tvalid && m_tready) begin
      act_rep = door_report_t'(m_tdata);
      if (pending_reports.size() == 0) begin
        report_fault("result with nothing pending (data word)", 0, 32'(m_tdata));
      end else begin
        exp_rep = pending_reports.pop_front();
        if (act_rep.state !== exp_rep.state)
          report_fault("door_state", 32'(exp_rep.state), 32'(act_rep.state));
        if (act_rep.position !== exp_rep.position)
          report_fault("travel_position", 32'(exp_rep.position), 32'(act_rep.position));
        if (act_rep.moving !== exp_rep.moving)
          report_fault("moving", 32'(exp_rep.moving), 32'(act_rep.moving));
        if (act_rep.countdown !== exp_rep.countdown)
          report_fault("close_countdown", 32'(exp_rep.countdown), 32'(act_rep.countdown));
        if (act_rep.pad !== exp_rep.pad)
          report_fault("padding bit", 32'(exp_rep.pad), 32'(act_rep.pad));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    src_idle = 12;
    snk_idle = 82;
    test_random_phase(8'd0, 2'd0, 320);
    src_idle = 82;
    snk_idle = 12;
    test_random_phase(8'd255, 2'd3, 300);
    src_idle = 0;
    snk_idle = 0;
    test_random_phase(8'd3, 2'd2, 240);
    test_receiver_hold();
    test_sender_pause();
    settle();
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== door_opener_controller_unit.f =====
+incdir+rtl/core
rtl/core/doc_pkg.sv
rtl/core/doc_step.sv
rtl/core/door_opener_controller_unit.sv
tb/door_opener_controller_unit_tb.sv
